>>> src/smi_pkg.sv
// Package for the smoothstep motion interpolator.
// Holds shared constants, register indexes and the lane control struct.
// No dependencies.
`timescale 1ns / 1ps
package smi_pkg;
  localparam int unsigned TimeBitsDefault = 22;
  localparam int unsigned CoordW = 16;
  localparam int unsigned WeightW = 11;
  localparam int unsigned ScaleW = 7;
  localparam int unsigned QBits = 10;
  localparam logic [WeightW-1:0] QOne = 11'd1024;
  localparam logic [ScaleW-1:0] ScaleLow = 7'd10;
  localparam logic [ScaleW-1:0] ScaleHigh = 7'd100;
  localparam logic [ScaleW-1:0] ScaleReset = 7'd100;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_CMIN  = 2'd1,
    REG_CMAX  = 2'd2
  } reg_idx_e;

  // Window and scale handed to every lane.
  typedef struct packed {
    logic signed [CoordW-1:0] cmin;
    logic signed [CoordW-1:0] cmax;
    logic [ScaleW-1:0]        scale;
  } lane_cfg_t;

  function automatic logic signed [CoordW-1:0] clamp_win(
    input logic signed [CoordW+1:0] v,
    input logic signed [CoordW-1:0] lo,
    input logic signed [CoordW-1:0] hi
  );
    logic signed [CoordW-1:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v[CoordW-1:0];
    return r;
  endfunction
endpackage

>>> src/smi_ease.sv
// Weight stage: pipelined restoring divider and smoothstep polynomial.
// Uses smi_pkg. One item per cycle while en_i is high.
`timescale 1ns / 1ps
module smi_ease #(
  parameter int unsigned TIME_BITS = smi_pkg::TimeBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [TIME_BITS-1:0]            elapsed_i,
  input  logic [TIME_BITS-1:0]            length_i,
  output logic [smi_pkg::WeightW-1:0]     weight_o
);
  localparam int unsigned NumW = TIME_BITS + smi_pkg::QBits;
  localparam int unsigned RemW = TIME_BITS + 1;

  logic [NumW-1:0]      num_q [NumW+1];
  logic [TIME_BITS-1:0] den_q [NumW+1];
  logic [RemW-1:0]      rem_q [NumW+1];
  logic                 full_q [NumW+1];

  // Stage 0 registers the operands; the quotient shifts into num from the right.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= {elapsed_i, {smi_pkg::QBits{1'b0}}};
      den_q[0]  <= length_i;
      rem_q[0]  <= '0;
      full_q[0] <= (length_i == '0) || (elapsed_i >= length_i);
    end
  end

  // One quotient bit per stage.
  for (genvar k = 0; k < NumW; k++) begin : g_div
    logic [RemW-1:0] trial;
    logic            ge;
    assign trial = {rem_q[k][RemW-2:0], num_q[k][NumW-1]};
    assign ge = trial >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? trial - {1'b0, den_q[k]} : trial;
        num_q[k+1]  <= {num_q[k][NumW-2:0], ge};
        den_q[k+1]  <= den_q[k];
        full_q[k+1] <= full_q[k];
      end
    end
  end

  // Polynomial: p*p, then times (3072 - 2p), then shift and saturate.
  logic [10:0] p_d, p_q, p2_q;
  logic [21:0] sq_q;
  logic [33:0] cube_q;
  logic        f1_q, f2_q, f3_q;
  logic [smi_pkg::WeightW-1:0] w_q;
  logic [10:0] sh;

  assign p_d = (num_q[NumW] > NumW'(smi_pkg::QOne)) ? smi_pkg::QOne : num_q[NumW][10:0];
  assign sh = cube_q[33:20] > 14'(smi_pkg::QOne) ? smi_pkg::QOne : cube_q[30:20];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      f1_q   <= full_q[NumW];
      sq_q   <= 22'(p_q) * 22'(p_q);
      p2_q   <= p_q;
      f2_q   <= f1_q;
      cube_q <= 34'(sq_q) * (34'(12'd3072) - 34'({p2_q, 1'b0}));
      f3_q   <= f2_q;
      w_q    <= f3_q ? smi_pkg::QOne : sh;
    end
  end
  assign weight_o = w_q;
endmodule

>>> src/smi_lane.sv
// One axis lane: eases between start and end with a delay-matched weight,
// clamps, then scales by percent and clamps again. Uses smi_pkg.
`timescale 1ns / 1ps
module smi_lane #(
  parameter int unsigned LAT = 36
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [smi_pkg::CoordW-1:0]   start_i,
  input  logic signed [smi_pkg::CoordW-1:0]   end_i,
  input  logic [smi_pkg::WeightW-1:0]         weight_i,
  input  smi_pkg::lane_cfg_t                  cfg_i,
  output logic signed [smi_pkg::CoordW-1:0]   pos_o,
  output logic signed [smi_pkg::CoordW-1:0]   drive_o
);
  // Delta computed at entry and carried down a shift line beside the weight.
  logic signed [16:0] dl_q [LAT];
  logic signed [15:0] st_q [LAT];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q[0] <= 17'(end_i) - 17'(start_i);
      st_q[0] <= start_i;
      for (int i = 1; i < LAT; i++) begin
        dl_q[i] <= dl_q[i-1];
        st_q[i] <= st_q[i-1];
      end
    end
  end

  // Multiply, truncating divide by 1024, clamp.
  logic signed [28:0] prod_q, prod_adj;
  logic signed [15:0] st2_q, pos_q;
  logic signed [17:0] sum;
  assign prod_adj = prod_q + (prod_q[28] ? 29'sd1023 : 29'sd0);
  assign sum = 18'(st2_q) + 18'(prod_adj >>> 10);

  // Drive: pos * percent / 100 by reciprocal 5243/2^19. The estimate is never
  // low and at most one too high, so a single compare corrects it.
  logic signed [22:0] dp_q;
  logic        [22:0] mag;
  logic        [36:0] qm_q;
  logic        [22:0] mag_q;
  logic               neg_q;
  logic signed [15:0] drv_q;
  assign mag = dp_q[22] ? -dp_q : dp_q;

  function automatic logic signed [17:0] dvq(input logic n, input logic [22:0] m,
                                             input logic [36:0] q);
    logic [17:0] a;
    logic [17:0] f;
    a = q[36:19];
    f = (25'(a) * 25'd100 > 25'(m)) ? a - 18'd1 : a;
    return n ? -$signed(f) : $signed(f);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 29'(dl_q[LAT-1]) * $signed({1'b0, weight_i});
      st2_q  <= st_q[LAT-1];
      pos_q  <= smi_pkg::clamp_win(sum, cfg_i.cmin, cfg_i.cmax);
      dp_q   <= 23'(pos_q) * $signed({1'b0, cfg_i.scale});
      qm_q   <= 37'(mag) * 37'd5243;
      mag_q  <= mag;
      neg_q  <= dp_q[22];
      drv_q  <= smi_pkg::clamp_win(dvq(neg_q, mag_q, qm_q), cfg_i.cmin, cfg_i.cmax);
    end
  end

  // Pos is delayed three stages to align with drive.
  logic signed [15:0] pd1_q, pd2_q, pd3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd1_q <= pos_q;
      pd2_q <= pd1_q;
      pd3_q <= pd2_q;
    end
  end
  assign pos_o = pd3_q;
  assign drive_o = drv_q;
endmodule

>>> src/smoothstep_motion_interpolator_top.sv
// Smoothstep motion interpolator. Pipeline stages: operand register 1,
// divider TIME_BITS+10, polynomial 4, lanes 5.
// Throughput one word per cycle; the pipeline stalls as a whole when the
// output word is not taken. Reset (async, active low) clears valids and
// sets scale 100, window -32768..32767. Uses smi_pkg, smi_ease, smi_lane.
`timescale 1ns / 1ps
module smoothstep_motion_interpolator_top #(
  parameter int unsigned TIME_BITS = smi_pkg::TimeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  start_x_i,
  input  logic signed [15:0]  start_y_i,
  input  logic signed [15:0]  end_x_i,
  input  logic signed [15:0]  end_y_i,
  input  logic [TIME_BITS-1:0] elapsed_time_i,
  input  logic [TIME_BITS-1:0] segment_length_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  pos_x_o,
  output logic signed [15:0]  pos_y_o,
  output logic signed [15:0]  drive_x_o,
  output logic signed [15:0]  drive_y_o,
  output logic [10:0]         ease_weight_o
);
  localparam int unsigned LatE = TIME_BITS + smi_pkg::QBits + 5;
  localparam int unsigned Lat = LatE + 5;

  // Configuration registers.
  smi_pkg::lane_cfg_t cfg_q;
  logic [6:0] sc;
  assign sc = cfg_data_i[6:0] < smi_pkg::ScaleLow ? smi_pkg::ScaleLow :
              cfg_data_i[6:0] > smi_pkg::ScaleHigh ? smi_pkg::ScaleHigh : cfg_data_i[6:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale <= smi_pkg::ScaleReset;
      cfg_q.cmin  <= 16'sh8000;
      cfg_q.cmax  <= 16'sh7fff;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smi_pkg::REG_SCALE: cfg_q.scale <= sc;
        smi_pkg::REG_CMIN:  cfg_q.cmin <= cfg_data_i;
        smi_pkg::REG_CMAX:  cfg_q.cmax <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global enable: the pipe advances unless the final word is held.
  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Lat-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], in_valid_i};
  end

  logic [10:0] w_e;
  smi_ease #(.TIME_BITS(TIME_BITS)) u_ease (
    .clk_i, .en_i(en), .elapsed_i(elapsed_time_i),
    .length_i(segment_length_i), .weight_o(w_e)
  );

  // Weight delayed to line up with the lane outputs.
  logic [10:0] wd_q [5];
  always_ff @(posedge clk_i) begin
    if (en) begin
      wd_q[0] <= w_e;
      for (int i = 1; i < 5; i++) wd_q[i] <= wd_q[i-1];
    end
  end
  assign ease_weight_o = wd_q[4];

  smi_lane #(.LAT(LatE)) u_lane_x (
    .clk_i, .en_i(en), .start_i(start_x_i), .end_i(end_x_i), .weight_i(w_e),
    .cfg_i(cfg_q), .pos_o(pos_x_o), .drive_o(drive_x_o)
  );
  smi_lane #(.LAT(LatE)) u_lane_y (
    .clk_i, .en_i(en), .start_i(start_y_i), .end_i(end_y_i), .weight_i(w_e),
    .cfg_i(cfg_q), .pos_o(pos_y_o), .drive_o(drive_y_o)
  );
endmodule

>>> src/smi_checker.sv
// Port checker for the interpolator top level, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module smi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [10:0] ease_weight_o
);
  a_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ease_weight_o <= 11'd1024) else $error("weight range");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("ready while stalled");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("word dropped");
endmodule

bind smoothstep_motion_interpolator_top smi_checker u_chk (.*);
